// File: rtl/fgcf_pkg.sv
// Shared types, constants and waveform lookups for the function generator
// with comb filter. Used by fgcf_comb and function_generator_comb_filter.
`timescale 1ns / 1ps
`default_nettype none

package fgcf_pkg;

  // comb delay line depth and pointer width
  localparam int unsigned DelayTaps = 20;
  localparam int unsigned PtrW      = (DelayTaps > 1) ? $clog2(DelayTaps) : 1;

  // sample ticks per 1 kHz period, table steps per period
  localparam int unsigned PeriodTicks = 50;
  localparam int unsigned TableSteps  = 100;

  // fsk phase steps
  localparam logic [3:0] FskStepLow  = 4'd2;
  localparam logic [3:0] FskStepHigh = 4'd10;

  // register map
  localparam logic AddrMode = 1'b0;

  typedef enum logic [1:0] {
    MODE_SINE     = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_FSK      = 2'd2,
    MODE_COMB     = 2'd3
  } mode_e;

  // control from the top level to the delay line
  typedef struct packed {
    logic step;   // an item is accepted, advance the pointer
    logic write;  // store the sample at the new pointer
  } comb_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sd32767;
    end else if (v < -17'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // first quarter of the sine, 32768*sin(2*pi*k/100), k = 0..25
  function automatic logic [16:0] quarter_sine(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0:  r = 17'd0;
      5'd1:  r = 17'd2058;
      5'd2:  r = 17'd4107;
      5'd3:  r = 17'd6140;
      5'd4:  r = 17'd8149;
      5'd5:  r = 17'd10126;
      5'd6:  r = 17'd12063;
      5'd7:  r = 17'd13952;
      5'd8:  r = 17'd15786;
      5'd9:  r = 17'd17558;
      5'd10: r = 17'd19261;
      5'd11: r = 17'd20887;
      5'd12: r = 17'd22431;
      5'd13: r = 17'd23887;
      5'd14: r = 17'd25248;
      5'd15: r = 17'd26510;
      5'd16: r = 17'd27667;
      5'd17: r = 17'd28715;
      5'd18: r = 17'd29649;
      5'd19: r = 17'd30467;
      5'd20: r = 17'd31164;
      5'd21: r = 17'd31739;
      5'd22: r = 17'd32188;
      5'd23: r = 17'd32510;
      5'd24: r = 17'd32703;
      5'd25: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // triangle ramp, round(65536*k/50), k = 0..25
  function automatic logic [16:0] tri_ramp(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0:  r = 17'd0;
      5'd1:  r = 17'd1311;
      5'd2:  r = 17'd2621;
      5'd3:  r = 17'd3932;
      5'd4:  r = 17'd5243;
      5'd5:  r = 17'd6554;
      5'd6:  r = 17'd7864;
      5'd7:  r = 17'd9175;
      5'd8:  r = 17'd10486;
      5'd9:  r = 17'd11796;
      5'd10: r = 17'd13107;
      5'd11: r = 17'd14418;
      5'd12: r = 17'd15729;
      5'd13: r = 17'd17039;
      5'd14: r = 17'd18350;
      5'd15: r = 17'd19661;
      5'd16: r = 17'd20972;
      5'd17: r = 17'd22282;
      5'd18: r = 17'd23593;
      5'd19: r = 17'd24904;
      5'd20: r = 17'd26214;
      5'd21: r = 17'd27525;
      5'd22: r = 17'd28836;
      5'd23: r = 17'd30147;
      5'd24: r = 17'd31457;
      5'd25: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // sine at table index q, q = 0..99
  function automatic logic signed [15:0] sine_at(input logic [6:0] q);
    logic [6:0]         k;
    logic               neg;
    logic [16:0]        mag;
    logic signed [16:0] v;
    if (q <= 7'd25) begin
      k   = q;
      neg = 1'b0;
    end else if (q <= 7'd50) begin
      k   = 7'd50 - q;
      neg = 1'b0;
    end else if (q <= 7'd75) begin
      k   = q - 7'd50;
      neg = 1'b1;
    end else begin
      k   = 7'd100 - q;
      neg = 1'b1;
    end
    mag = quarter_sine(k[4:0]);
    v   = neg ? -$signed(mag) : $signed(mag);
    return sat16(v);
  endfunction

  // triangle at half-sample h, h = 0..99; peak +1.0 at h = 50
  function automatic logic signed [15:0] triangle_at(input logic [6:0] h);
    logic [6:0]         k;
    logic               neg;
    logic [16:0]        mag;
    logic signed [16:0] v;
    // distance from the peak is d = |h-50|; value is +-ramp(|25-d|)
    if (h < 7'd25) begin
      k   = 7'd25 - h;
      neg = 1'b1;
    end else if (h < 7'd50) begin
      k   = h - 7'd25;
      neg = 1'b0;
    end else if (h < 7'd75) begin
      k   = 7'd75 - h;
      neg = 1'b0;
    end else begin
      k   = h - 7'd75;
      neg = 1'b1;
    end
    mag = tri_ramp(k[4:0]);
    v   = neg ? -$signed(mag) : $signed(mag);
    return sat16(v);
  endfunction

endpackage

`default_nettype wire

// File: rtl/fgcf_comb.sv
// Delay line of the comb filter: DelayTaps samples in flops with a
// circular pointer. Depends on fgcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgcf_comb (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fgcf_pkg::comb_ctrl_t  ctrl_i,
  input  wire logic signed [15:0]    sample_i,
  output logic signed [15:0]         tap_o
);

  logic [fgcf_pkg::PtrW-1:0] ptr_q, ptr_d;
  logic signed [15:0]        store_q [fgcf_pkg::DelayTaps];

  // pointer advances before use
  always_comb begin
    if (ptr_q == fgcf_pkg::PtrW'(fgcf_pkg::DelayTaps - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + fgcf_pkg::PtrW'(1);
    end
  end

  assign tap_o = store_q[ptr_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < int'(fgcf_pkg::DelayTaps); i++) begin
        store_q[i] <= '0;
      end
    end else if (ctrl_i.step) begin
      ptr_q <= ptr_d;
      if (ctrl_i.write) begin
        store_q[ptr_d] <= sample_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/function_generator_comb_filter.sv
// Top level of the function generator with comb filter: stream ports, APB
// mode register, phase counters and output register. Uses fgcf_pkg, fgcf_comb.
`timescale 1ns / 1ps
`default_nettype none

// One input sample in, one right/left sample pair out, one item per clock.
// Each accepted item is processed in the cycle it is accepted: the phase
// counters, peak tracker and delay line update at that edge and the result
// lands in the output register, so an item's result is offered in the cycle
// after acceptance. The output register lets a new item enter in the same
// cycle the held result is taken; throughput is one item per cycle as long
// as the downstream side keeps m_axis_tready_i high. The mode register
// (byte address 0) selects dual sine, dual triangle, level-keyed FSK or the
// comb filter; write it only while no item is in flight.
module function_generator_comb_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] sample_in
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [15:0] right_sample, [31:16] left_sample
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  fgcf_pkg::mode_e mode_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == fgcf_pkg::AddrMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fgcf_pkg::MODE_SINE;
    end else if (cfg_wr) begin
      mode_q <= fgcf_pkg::mode_e'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fgcf_pkg::AddrMode) begin
      prdata[1:0] = mode_q;
    end
  end

  // ---------------------------------------------------------------------
  // handshake: output register frees up when its item is taken
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  // ---------------------------------------------------------------------
  // per-item state
  // ---------------------------------------------------------------------
  logic signed [15:0] x;
  logic [5:0]         tick_q, tick_d;   // sample count mod 50
  logic [6:0]         fsk_q, fsk_d;     // sine index mod 100
  logic signed [15:0] peak_q, peak_d;   // running max of the input, tracked in FSK mode
  logic               is_fsk;

  assign x      = $signed(s_axis_tdata_i);
  assign is_fsk = (mode_q == fgcf_pkg::MODE_FSK);

  // tick advances before use
  always_comb begin
    if (tick_q == 6'(fgcf_pkg::PeriodTicks - 1)) begin
      tick_d = '0;
    end else begin
      tick_d = tick_q + 6'd1;
    end
  end

  // fsk: track peak, pick the step on 5*x < 4*peak, advance mod 100
  logic signed [18:0] x_times5;
  logic signed [18:0] peak_times4;
  logic [3:0]         fsk_step;
  logic [6:0]         fsk_sum;
  logic signed [15:0] peak_new;

  assign peak_new    = (x > peak_q) ? x : peak_q;
  assign x_times5    = {{3{x[15]}}, x} + {x[15], x, 2'b00};
  assign peak_times4 = {peak_new[15], peak_new, 2'b00};
  assign fsk_step    = (x_times5 < peak_times4) ? fgcf_pkg::FskStepLow
                                                : fgcf_pkg::FskStepHigh;
  assign fsk_sum     = fsk_q + {3'b000, fsk_step};

  always_comb begin
    peak_d = peak_q;
    fsk_d  = fsk_q;
    if (is_fsk) begin
      peak_d = peak_new;
      if (fsk_sum >= 7'(fgcf_pkg::TableSteps)) begin
        fsk_d = fsk_sum - 7'(fgcf_pkg::TableSteps);
      end else begin
        fsk_d = fsk_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      fsk_q  <= '0;
      peak_q <= -16'sd32768;
    end else if (accept) begin
      tick_q <= tick_d;
      fsk_q  <= fsk_d;
      peak_q <= peak_d;
    end
  end

  // ---------------------------------------------------------------------
  // comb delay line
  // ---------------------------------------------------------------------
  fgcf_pkg::comb_ctrl_t comb_ctrl;
  logic signed [15:0]   comb_tap;
  logic signed [16:0]   comb_sum;

  assign comb_ctrl.step  = accept;
  assign comb_ctrl.write = (mode_q == fgcf_pkg::MODE_COMB);

  fgcf_comb u_comb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (comb_ctrl),
    .sample_i (x),
    .tap_o    (comb_tap)
  );

  // (x + x[n-taps]) >> 1, floor
  assign comb_sum = {x[15], x} + {comb_tap[15], comb_tap};

  // ---------------------------------------------------------------------
  // waveform indexes
  // ---------------------------------------------------------------------
  logic [6:0] idx_1k;      // 2*tick, 0..98
  logic [7:0] idx_2k_raw;  // 4*tick, 0..196
  logic [6:0] idx_2k;
  logic [6:0] idx_quad_raw;
  logic [6:0] idx_quad;    // quarter cycle ahead

  assign idx_1k       = {tick_d, 1'b0};
  assign idx_2k_raw   = {tick_d, 2'b00};
  assign idx_2k       = (idx_2k_raw >= 8'(fgcf_pkg::TableSteps))
                        ? 7'(idx_2k_raw - 8'(fgcf_pkg::TableSteps)) : idx_2k_raw[6:0];
  assign idx_quad_raw = idx_1k + 7'd25;
  assign idx_quad     = (idx_quad_raw >= 7'(fgcf_pkg::TableSteps))
                        ? idx_quad_raw - 7'(fgcf_pkg::TableSteps) : idx_quad_raw;

  // ---------------------------------------------------------------------
  // result select and output register
  // ---------------------------------------------------------------------
  logic signed [15:0] right_d, left_d;
  logic signed [15:0] right_q, left_q;

  always_comb begin
    case (mode_q)
      fgcf_pkg::MODE_SINE: begin
        right_d = fgcf_pkg::sine_at(idx_1k);
        left_d  = fgcf_pkg::sine_at(idx_2k);
      end
      fgcf_pkg::MODE_TRIANGLE: begin
        right_d = fgcf_pkg::triangle_at(idx_1k);
        left_d  = fgcf_pkg::triangle_at(idx_quad);
      end
      fgcf_pkg::MODE_FSK: begin
        right_d = x;
        left_d  = fgcf_pkg::sine_at(fsk_d);
      end
      default: begin
        right_d = x;
        left_d  = comb_sum[16:1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      right_q <= right_d;
      left_q  <= left_d;
    end
  end

  assign m_axis_tdata_o = {left_q, right_q};

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_tick_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < 6'(fgcf_pkg::PeriodTicks))
    else $error("tick phase out of range");

  a_fsk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsk_q < 7'(fgcf_pkg::TableSteps))
    else $error("fsk phase out of range");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted item gave no result");

  a_peak_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_fsk) |=> (peak_q >= $past(x)))
    else $error("peak below an accepted sample");

endmodule

`default_nettype wire
